// File: rtl/gle_pkg.sv
// ============================================================================
// gle_pkg: shared types and constants of the grayscale Laplacian edge block
// Transaction structs for both ports, the column record passed from the
// front end to the back end, register indexes and fixed constants.
// ============================================================================
package gle_pkg;

    // field widths
    localparam int GRAY_W = 6;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;

    // register reset values and limits
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam int               DIM_MIN      = 3;
    localparam int               HEIGHT_MAX   = 1024;

    // luma weights for R, G, B
    localparam logic [7:0] COEF_R = 8'd158;
    localparam logic [7:0] COEF_G = 8'd152;
    localparam logic [7:0] COEF_B = 8'd60;

    // largest edge value
    localparam logic [15:0] EDGE_MAX = 16'hFFFF;

    // queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // configuration register indexes
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_gle_reg;

    // input transaction
    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic        frame_start;
    } t_gle_in;

    // result transaction
    typedef struct packed {
        logic [15:0]      edge_value;
        logic [POS_W-1:0] out_column;
        logic [POS_W-1:0] out_row;
        logic             frame_last;
    } t_gle_out;

    // one new window column plus result bookkeeping
    typedef struct packed {
        logic [GRAY_W-1:0] above;
        logic [GRAY_W-1:0] up;
        logic [GRAY_W-1:0] gray;
        logic              emit;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic              last;
    } t_gle_col;

endpackage

// File: rtl/gle_front.sv
// ============================================================================
// gle_front: pixel intake, gray conversion, raster position, line buffer
// Takes one pixel per cycle while not full, tracks row and column, reads and
// rewrites the two-line store, hands a finished window column to the queue.
// ============================================================================
module gle_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  gle_pkg::t_gle_reg  i_cfg_index,
    input  logic [10:0]        i_cfg_wdata,
    input  logic               i_push,
    input  gle_pkg::t_gle_in   i_pixel,
    output logic               o_full,
    input  logic               i_q_full,
    output logic               o_q_push,
    output gle_pkg::t_gle_col  o_q_data
);
    import gle_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col;
    logic [POS_W-1:0] r_row;

    logic [CW:0]      w_use;
    logic [CFG_W-1:0] h_use;
    logic [CW-1:0]    cur_col;
    logic [POS_W-1:0] cur_row;
    logic             col_end;
    logic             row_end;
    logic [CW-1:0]    n_col;
    logic [POS_W-1:0] n_row;
    logic [POS_W-1:0] col_m1;
    logic [13:0]      luma_sum;
    logic [5:0]       gray;
    logic             emit;
    logic             last;
    logic             accept;
    logic             f_adv;

    // stage F1
    logic                r_f_valid;
    logic [GRAY_W-1:0]   r_f_gray;
    logic                r_f_emit;
    logic [POS_W-1:0]    r_f_column;
    logic [POS_W-1:0]    r_f_row;
    logic                r_f_last;
    logic [CW-1:0]       r_f_addr;

    // line store: {middle row, upper row} per column
    logic [2*GRAY_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*GRAY_W-1:0] r_rd;
    logic                r_fwd_hit;
    logic [2*GRAY_W-1:0] r_fwd_data;
    logic [2*GRAY_W-1:0] line_eff;
    logic [2*GRAY_W-1:0] wr_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp frame size to usable range
    always_comb begin
        if (32'(r_frame_width) < DIM_MIN) begin
            w_use = (CW+1)'(DIM_MIN);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_use = (CW+1)'(MAX_WIDTH);
        end else begin
            w_use = (CW+1)'(r_frame_width);
        end
        if (32'(r_frame_height) < DIM_MIN) begin
            h_use = CFG_W'(DIM_MIN);
        end else if (32'(r_frame_height) > HEIGHT_MAX) begin
            h_use = CFG_W'(HEIGHT_MAX);
        end else begin
            h_use = r_frame_height;
        end
    end

    // handshake
    assign f_adv  = r_f_valid && !i_q_full;
    assign o_full = r_f_valid && i_q_full;
    assign accept = i_push && !o_full;

    // raster position of the incoming pixel
    always_comb begin
        cur_col = i_pixel.frame_start ? '0 : r_col;
        cur_row = i_pixel.frame_start ? '0 : r_row;
        col_end = ((CW+1)'(cur_col) + (CW+1)'(1)) >= w_use;
        row_end = (CFG_W'(cur_row) + CFG_W'(1)) >= h_use;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : cur_row + POS_W'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
        emit   = (cur_col >= CW'(2)) && (cur_row >= POS_W'(2));
        last   = (CFG_W'(cur_row) == h_use - CFG_W'(1)) &&
                 ((CW+1)'(cur_col) == w_use - (CW+1)'(1));
        col_m1 = POS_W'(cur_col) - POS_W'(1);
    end

    // gray value, bits 13:8 of the weighted sum
    always_comb begin
        luma_sum = 14'({9'b0, i_pixel.pixel_rgb565[15:11]} * 14'(COEF_R))
                 + 14'({8'b0, i_pixel.pixel_rgb565[10:5]}  * 14'(COEF_G))
                 + 14'({9'b0, i_pixel.pixel_rgb565[4:0]}   * 14'(COEF_B));
        gray     = luma_sum[13:8];
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage F1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (accept) begin
                r_f_valid <= 1'b1;
                r_fwd_hit <= f_adv && (cur_col == r_f_addr);
            end else if (f_adv) begin
                r_f_valid <= 1'b0;
            end
        end
    end

    // stage F1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_gray   <= gray;
            r_f_emit   <= emit;
            r_f_column <= col_m1;
            r_f_row    <= cur_row - POS_W'(1);
            r_f_last   <= last;
            r_f_addr   <= cur_col;
            r_fwd_data <= wr_data;
        end
    end

    // a write to the column just read is forwarded
    assign line_eff = r_fwd_hit ? r_fwd_data : r_rd;
    assign wr_data  = {r_f_gray, line_eff[2*GRAY_W-1:GRAY_W]};

    // line store: write back on retire, registered read on intake
    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_line_mem[r_f_addr] <= wr_data;
        end
        if (accept) begin
            r_rd <= r_line_mem[cur_col];
        end
    end

    // column record to the queue
    assign o_q_push        = f_adv;
    assign o_q_data.above  = line_eff[GRAY_W-1:0];
    assign o_q_data.up     = line_eff[2*GRAY_W-1:GRAY_W];
    assign o_q_data.gray   = r_f_gray;
    assign o_q_data.emit   = r_f_emit;
    assign o_q_data.column = r_f_column;
    assign o_q_data.row    = r_f_row;
    assign o_q_data.last   = r_f_last;

    // intake never overwrites a stage that has not retired
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_f_valid |-> f_adv)
        else $error("front stage overwritten before retire");

    // back pressure only comes from a held stage
    a_full_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_f_valid)
        else $error("front stage lost while full");

endmodule

// File: rtl/gle_queue.sv
// ============================================================================
// gle_queue: short register queue between front and back end
// Holds window columns in order so that each side can stall on its own.
// ============================================================================
module gle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gle_pkg::t_gle_col i_data,
    output logic              o_full,
    output logic              o_valid,
    output gle_pkg::t_gle_col o_data,
    input  logic              i_pop
);
    import gle_pkg::*;

    t_gle_col            r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

// File: rtl/gle_back.sv
// ============================================================================
// gle_back: 3x3 window, Laplacian and result register
// Shifts every column into the window, forms the two partial sums, scales
// them into the packed 565 Laplacian, clamps and holds the result.
// ============================================================================
module gle_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  gle_pkg::t_gle_col i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output gle_pkg::t_gle_out o_result
);
    import gle_pkg::*;

    logic [GRAY_W-1:0] r_win [9];
    logic [GRAY_W-1:0] n_win [9];
    logic [7:0]        sum_h;
    logic [8:0]        sum_g;
    logic signed [9:0] n_dh;
    logic signed [9:0] n_dg;

    // stage B1
    logic              r_b_valid;
    logic              r_b_emit;
    logic signed [9:0] r_b_dh;
    logic signed [9:0] r_b_dg;
    logic [POS_W-1:0]  r_b_column;
    logic [POS_W-1:0]  r_b_row;
    logic              r_b_last;

    // result register
    logic              r_o_valid;
    t_gle_out          r_o_data;

    logic               o_load;
    logic               b_ready;
    logic signed [20:0] acc;
    logic [15:0]        edge_val;

    assign o_load  = r_b_valid && r_b_emit && (!r_o_valid || i_pop);
    assign b_ready = !r_b_valid || !r_b_emit || !r_o_valid || i_pop;
    assign o_q_pop = i_q_valid && b_ready;

    // window after shifting in the new column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]     = r_win[k*3+1];
            n_win[k*3+1]   = r_win[k*3+2];
        end
        n_win[2] = i_q_data.above;
        n_win[5] = i_q_data.up;
        n_win[8] = i_q_data.gray;
    end

    // neighbor sums of the half value and the full value
    always_comb begin
        sum_h = '0;
        sum_g = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                sum_h = sum_h + 8'(n_win[k][5:1]);
                sum_g = sum_g + 9'(n_win[k]);
            end
        end
        n_dh = signed'({2'b0, n_win[4][5:1], 3'b0}) - signed'({2'b0, sum_h});
        n_dg = signed'({1'b0, n_win[4], 3'b0}) - signed'({1'b0, sum_g});
    end

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (o_q_pop) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // stage B1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_b_valid <= 1'b1;
        end else if (b_ready) begin
            r_b_valid <= 1'b0;
        end
    end

    // stage B1 payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_emit   <= i_q_data.emit;
            r_b_dh     <= n_dh;
            r_b_dg     <= n_dg;
            r_b_column <= i_q_data.column;
            r_b_row    <= i_q_data.row;
            r_b_last   <= i_q_data.last;
        end
    end

    // packed word is 2049*half + 32*gray, so scale the two sums and clamp
    always_comb begin
        acc = ({{11{r_b_dh[9]}}, r_b_dh} <<< 11)
            + {{11{r_b_dh[9]}}, r_b_dh}
            + ({{11{r_b_dg[9]}}, r_b_dg} <<< 5);
        if (acc[20]) begin
            edge_val = '0;
        end else if (acc[19:16] != 4'b0) begin
            edge_val = EDGE_MAX;
        end else begin
            edge_val = acc[15:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_pop) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_data.edge_value <= edge_val;
            r_o_data.out_column <= r_b_column;
            r_o_data.out_row    <= r_b_row;
            r_o_data.frame_last <= r_b_last;
        end
    end

    assign o_empty  = !r_o_valid;
    assign o_result = r_o_data;

    // a column taken from the queue always lands in B1
    a_pop_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_b_valid)
        else $error("popped column not held in B1");

    // a result held in B1 waits while the result register is blocked
    a_b1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_emit && r_o_valid && !i_pop |=> r_b_valid && $stable(r_b_dh))
        else $error("pending result dropped from B1");

endmodule

// File: rtl/grayscale_laplacian_edge.sv
// ============================================================================
// grayscale_laplacian_edge: 3x3 Laplacian edge detector on RGB565 video
// Converts each pixel to a 6-bit gray value, keeps two lines and a 3x3
// window and emits a clamped Laplacian for every interior pixel.
// ============================================================================
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  pixel in  | push / full           | i_pixel  (pixel_rgb565, frame_start)
//  result    | pop / empty           | o_result (edge_value, out_column,
//            |                       |           out_row, frame_last)
//  config    | i_cfg_we              | i_cfg_index, i_cfg_wdata
//
//  One pixel per cycle sustained while full stays low; the line store has one
//  read and one write port, used once per pixel each.
//  A result passes stage F1, the column queue, B1 and the result register
//  after the pixel that completes its window; border pixels give none.
//  Reset (synchronous, i_rst_n low) clears counters, window and valid bits;
//  the line store is not cleared.
//  A stall on pop backs up through result register, B1 and a four-entry
//  column queue before full rises.
//
module grayscale_laplacian_edge #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  gle_pkg::t_gle_reg  i_cfg_index,
    input  logic [10:0]        i_cfg_wdata,
    input  logic               push,
    input  gle_pkg::t_gle_in   i_pixel,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output gle_pkg::t_gle_out  o_result
);
    import gle_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_gle_col q_in;
    t_gle_col q_out;

    // intake, gray conversion and line store
    gle_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    // decoupling queue
    gle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    // window, Laplacian and result register
    gle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// File: test/tb.sv
// ============================================================================
// tb: self-checking bench for the grayscale Laplacian edge detector
// Streams RGB565 frames through the queue-style pixel port, predicts every
// Laplacian result from its own copy of the line stores and window, and
// checks each popped result field by field. Both sides idle at random.
// ============================================================================
module tb;
    import gle_pkg::*;

    localparam int LINE_MAX    = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_MAX   = 50000;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_MAX  = 200;

    // clock, reset and block ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    t_gle_reg    i_cfg_index = REG_FRAME_WIDTH;
    logic [10:0] i_cfg_wdata = '0;
    logic        push        = 1'b0;
    t_gle_in     i_pixel     = '0;
    logic        full;
    logic        empty;
    logic        pop         = 1'b0;
    t_gle_out    o_result;

    // pixels waiting to be offered, results waiting to be popped
    t_gle_in  pixel_feed[$];
    t_gle_out edges_due[$];

    // predictor state
    logic [CFG_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [CFG_W-1:0]  cfg_height = HEIGHT_RESET;
    bit   [GRAY_W-1:0] line_upper [LINE_MAX];
    bit   [GRAY_W-1:0] line_mid   [LINE_MAX];
    bit   [GRAY_W-1:0] win_gray   [9];
    int                col_pos = 0;
    int                row_pos = 0;

    // traffic shaping
    int   send_idle_pct = 0;
    int   pop_stall_pct = 0;
    logic hold_go       = 1'b0;
    int   hold_left     = 0;

    // bookkeeping
    int cycle_count    = 0;
    int failures       = 0;
    int pixels_in      = 0;
    int edges_checked  = 0;
    int frames_closed  = 0;
    int stalled_cycles = 0;

    grayscale_laplacian_edge #(
        .MAX_WIDTH(LINE_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .i_pixel    (i_pixel),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register value held to the legal range
    function automatic int dim_in_use(logic [CFG_W-1:0] v, int top);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > top) return top;
        return int'(v);
    endfunction

    // gray value repacked as a 565 word: red = blue = g>>1, green = g
    function automatic int pack565(bit [GRAY_W-1:0] g);
        return int'({g[5:1], g, g[5:1]});
    endfunction

    // advance the predictor by one accepted pixel
    task automatic compute_edge(input t_gle_in px);
        logic [4:0]        red, blue;
        logic [5:0]        green;
        bit   [GRAY_W-1:0] gray, above, up;
        int                sum, acc, span_w, span_h, slot;
        t_gle_out          res;
        span_w = dim_in_use(cfg_width, LINE_MAX);
        span_h = dim_in_use(cfg_height, HEIGHT_MAX);
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        red   = px.pixel_rgb565[15:11];
        green = px.pixel_rgb565[10:5];
        blue  = px.pixel_rgb565[4:0];
        sum   = COEF_R * red + COEF_G * green + COEF_B * blue;
        gray  = sum[13:8];

        // line stores feed the new right column of the window
        slot  = col_pos % LINE_MAX;
        up    = line_mid[slot];
        above = line_upper[slot];
        line_upper[slot] = up;
        line_mid[slot]   = gray;
        for (int k = 0; k < 3; k++) begin
            win_gray[k*3]   = win_gray[k*3+1];
            win_gray[k*3+1] = win_gray[k*3+2];
        end
        win_gray[2] = above;
        win_gray[5] = up;
        win_gray[8] = gray;

        // interior pixel: 8*centre minus the neighbours, clamped
        if (col_pos >= 2 && row_pos >= 2) begin
            acc = 8 * pack565(win_gray[4]);
            for (int k = 0; k < 9; k++) begin
                if (k != 4) acc -= pack565(win_gray[k]);
            end
            if (acc < 0) acc = 0;
            else if (acc > int'(EDGE_MAX)) acc = int'(EDGE_MAX);
            res.edge_value = acc[15:0];
            res.out_column = POS_W'(col_pos - 1);
            res.out_row    = POS_W'(row_pos - 1);
            res.frame_last = (row_pos == span_h - 1) && (col_pos == span_w - 1);
            edges_due.push_back(res);
        end

        if (col_pos + 1 >= span_w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= span_h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                compute_edge(i_pixel);
                pixels_in++;
            end
            if (push && full) begin
                stalled_cycles++;
            end else if (pixel_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                push    <= 1'b1;
                i_pixel <= pixel_feed.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_gle_out want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                edges_checked++;
                if (o_result.frame_last) frames_closed++;
                if (edges_due.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, o_result);
                end else begin
                    want = edges_due.pop_front();
                    if (o_result.edge_value !== want.edge_value) begin
                        failures++;
                        if (failures <= REPORT_MAX)
                            $display("%0t: edge_value expected %h, got %h",
                                     $time, want.edge_value, o_result.edge_value);
                    end
                    if (o_result.out_column !== want.out_column) begin
                        failures++;
                        if (failures <= REPORT_MAX)
                            $display("%0t: out_column expected %0d, got %0d",
                                     $time, want.out_column, o_result.out_column);
                    end
                    if (o_result.out_row !== want.out_row) begin
                        failures++;
                        if (failures <= REPORT_MAX)
                            $display("%0t: out_row expected %0d, got %0d",
                                     $time, want.out_row, o_result.out_row);
                    end
                    if (o_result.frame_last !== want.frame_last) begin
                        failures++;
                        if (failures <= REPORT_MAX)
                            $display("%0t: frame_last expected %b, got %b",
                                     $time, want.frame_last, o_result.frame_last);
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // wait until every pixel is in and every result is out, then let the
    // pipeline flush trailing border pixels
    task drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        while ((pixel_feed.size() != 0 || push || edges_due.size() != 0)
               && waited < DRAIN_MAX) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write both frame registers while the block is idle
    task write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
    endtask

    task put_pixel(input logic [15:0] v, input logic s);
        t_gle_in px;
        px.pixel_rgb565 = v;
        px.frame_start  = s;
        pixel_feed.push_back(px);
    endtask

    // queue frames of w x h pixels with random content; some frames are cut
    // short and a few stray frame starts land mid-frame unless whole is set
    task queue_frames(input int target, input int w, input int h,
                      input logic force_start, input logic whole);
        int          added, frame_len, style;
        logic [15:0] flat, v;
        logic        s;
        added = 0;
        @(negedge i_clk);
        while (added < target) begin
            frame_len = w * h;
            if (!whole && $urandom_range(0, 9) == 0) frame_len = $urandom_range(1, frame_len);
            style = $urandom_range(0, 3);
            flat  = 16'($urandom);
            for (int k = 0; k < frame_len && added < target; k++) begin
                case (style)
                    0: v = 16'($urandom);
                    1: v = ($urandom_range(0, 15) == 0) ? 16'($urandom) : flat;
                    2: v = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'h0000;
                    default: begin
                        case ($urandom_range(0, 4))
                            0: v = 16'h0000;
                            1: v = 16'hFFFF;
                            2: v = 16'hF800;
                            3: v = 16'h07E0;
                            default: v = 16'h001F;
                        endcase
                    end
                endcase
                s = (k == 0) && (force_start || $urandom_range(0, 7) != 0);
                if (!whole && $urandom_range(0, 49) == 0) s = 1'b1;
                force_start = 1'b0;
                put_pixel(v, s);
                added++;
            end
        end
    endtask

    // test sequence
    initial begin : sequencer
        int   w, h;
        logic grows;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero registers clamp to a 3x3 frame; bright centre clamps
        // high, dark centre clamps to zero, second frame arrives by wrap-around
        write_dims(11'd0, 11'd0);
        @(negedge i_clk);
        put_pixel(16'h0000, 1'b1);
        repeat (3) put_pixel(16'h0000, 1'b0);
        put_pixel(16'hFFFF, 1'b0);
        repeat (4) put_pixel(16'h0000, 1'b0);
        repeat (4) put_pixel(16'hFFFF, 1'b0);
        put_pixel(16'h0000, 1'b0);
        repeat (4) put_pixel(16'hFFFF, 1'b0);
        put_pixel(16'hF800, 1'b1);
        put_pixel(16'h07E0, 1'b0);
        put_pixel(16'h001F, 1'b0);
        put_pixel(16'h8410, 1'b0);
        put_pixel(16'h7BEF, 1'b0);
        put_pixel(16'hFFFF, 1'b0);
        put_pixel(16'h0000, 1'b0);
        put_pixel(16'h5555, 1'b0);
        put_pixel(16'hAAAA, 1'b0);
        drain();

        // narrow line, height register above range, long receiver hold-off
        // while the sender keeps offering pixels
        send_idle_pct <= 0;
        pop_stall_pct <= 0;
        write_dims(11'd8, 11'd2047);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        queue_frames(150, 8, HEIGHT_MAX, 1'b1, 1'b1);
        drain();

        // random phases over the idling patterns
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct <= 0;  pop_stall_pct <= 0;  end
                1: begin send_idle_pct <= 84; pop_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  pop_stall_pct <= 84; end
                default: begin send_idle_pct <= 9; pop_stall_pct <= 9; end
            endcase
            case ($urandom_range(0, 11))
                0, 1: w = $urandom_range(0, 2);
                2: w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 11))
                0, 1: h = $urandom_range(0, 2);
                2: h = $urandom_range(1025, 2047);
                default: h = $urandom_range(3, 8);
            endcase
            // a wider line must start a fresh frame; a narrower one may cut
            // into the current line
            grows = dim_in_use(CFG_W'(w), LINE_MAX) > dim_in_use(cfg_width, LINE_MAX);
            write_dims(CFG_W'(w), CFG_W'(h));
            queue_frames($urandom_range(45, 65), dim_in_use(CFG_W'(w), LINE_MAX),
                         dim_in_use(CFG_W'(h), HEIGHT_MAX), grows, 1'b0);
            drain();
        end

        if (edges_due.size() != 0) begin
            failures += edges_due.size();
            $display("%0t: %0d expected results never arrived", $time, edges_due.size());
        end
        $display("summary: %0d pixels accepted, %0d edge results checked, %0d frame ends",
                 pixels_in, edges_checked, frames_closed);
        $display("summary: input held back by full on %0d cycles, %0d mismatches",
                 stalled_cycles, failures);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
